FILE: src/assert_macros.svh
// Assertion macros used by the port-level checker file of the grid stepper.
// Each macro takes a label, an antecedent and a consequent; clk and rst come from scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TLG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("grid stepper check failed");

// Next-cycle implication, disabled during reset.
`define TLG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("grid stepper check failed");

`endif

FILE: src/tlg_pkg.sv
// Shared types and constants of the toroidal grid stepper.
// No dependencies; used by the interfaces, the core and the checker.
package tlg_pkg;

  // Command codes carried in the mode field.
  typedef enum logic {
    MODE_SEED = 1'b0,
    MODE_STEP = 1'b1
  } mode_t;

  localparam int ROW_W      = 8;
  localparam int ROW_IDX_W  = 3;
  localparam int GRID_W     = 64;
  localparam int COUNT_W    = 4;

  // Neighbor counts of the life rule.
  localparam logic [COUNT_W-1:0] STAY_COUNT  = 4'd2;
  localparam logic [COUNT_W-1:0] BIRTH_COUNT = 4'd3;

endpackage

FILE: src/tlg_if.sv
// Valid/ready channel interfaces for the command and result items.
// Depends on tlg_pkg for field widths and the mode type.
interface life_in_if;
  import tlg_pkg::*;
  logic                 valid;
  logic                 ready;
  mode_t                mode;
  logic [ROW_IDX_W-1:0] row_index;
  logic [ROW_W-1:0]     row_bits;

  modport source (output valid, output mode, output row_index, output row_bits, input ready);
  modport sink   (input valid, input mode, input row_index, input row_bits, output ready);
endinterface

interface life_out_if;
  import tlg_pkg::*;
  logic              valid;
  logic              ready;
  logic [GRID_W-1:0] grid_bits;

  modport source (output valid, output grid_bits, input ready);
  modport sink   (input valid, input grid_bits, output ready);
endinterface

FILE: src/toroidal_life_grid_stepper_core.sv
// Toroidal life grid stepper: keeps a GRID_SIZE x GRID_SIZE grid of cells.
// Channel cmd carries items of mode, row_index and row_bits; channel result
// carries one item per command: the whole grid packed with row y in bits 8y..8y+7.
// A seed item (mode 0) writes one row; its result is valid the
// cycle after acceptance. A row index at or beyond GRID_SIZE leaves the grid as is.
// A step item (mode 1) runs one pass over all GRID_SIZE*GRID_SIZE cells:
// one neighbor counter and rule unit evaluates the cell at the corner of the grid
// each cycle while the grid rotates under it, so every cell passes that corner once.
// The new generation collects in a second grid that rotates in lockstep and is
// copied over the grid at the end of the pass, when the result becomes valid.
// cmd.ready is high only while no step runs and the result register is free or
// being taken in the same cycle; a stalled receiver thus holds off new items.
// Reset (rst, synchronous) clears the grid to all dead cells and drops any
// pending result.
module toroidal_life_grid_stepper_core #(
  parameter int GRID_SIZE = 8
) (
  input logic        clk,
  input logic        rst,
  life_in_if.sink    cmd,
  life_out_if.source result
);
  import tlg_pkg::*;

  localparam int IDX_W = $clog2(GRID_SIZE);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(GRID_SIZE - 1);

  typedef enum logic {
    S_IDLE,
    S_STEP
  } state_t;

  typedef logic [GRID_SIZE-1:0] grid_row_t;

  state_t            state;
  grid_row_t         grid [GRID_SIZE];
  grid_row_t         nxt  [GRID_SIZE];
  logic [IDX_W-1:0]  col;
  logic [IDX_W-1:0]  row;
  logic              out_valid;
  logic [GRID_W-1:0] out_bits;

  grid_row_t         grid_h    [GRID_SIZE];
  grid_row_t         grid_hv   [GRID_SIZE];
  grid_row_t         nxt_upd   [GRID_SIZE];
  grid_row_t         nxt_h     [GRID_SIZE];
  grid_row_t         nxt_hv    [GRID_SIZE];
  grid_row_t         seed_grid [GRID_SIZE];
  grid_row_t         pack_src  [GRID_SIZE];
  logic [COUNT_W-1:0] count;
  logic              cell_next;
  logic [GRID_W-1:0] packed_bits;
  logic              accept;

  assign accept       = cmd.valid && cmd.ready;
  assign cmd.ready    = (state == S_IDLE) && (!out_valid || result.ready);
  assign result.valid = out_valid;
  assign result.grid_bits = out_bits;

  // Neighbor count and life rule for the cell at row 0, column 0.
  always_comb begin
    count = {3'b000, grid[GRID_SIZE-1][GRID_SIZE-1]}
          + {3'b000, grid[GRID_SIZE-1][0]}
          + {3'b000, grid[GRID_SIZE-1][1]}
          + {3'b000, grid[0][GRID_SIZE-1]}
          + {3'b000, grid[0][1]}
          + {3'b000, grid[1][GRID_SIZE-1]}
          + {3'b000, grid[1][0]}
          + {3'b000, grid[1][1]};
    if (grid[0][0]) begin
      cell_next = (count == STAY_COUNT) || (count == BIRTH_COUNT);
    end else begin
      cell_next = (count == BIRTH_COUNT);
    end
  end

  // Rotations of both grids: by one column, or by one column and one row.
  always_comb begin
    for (int r = 0; r < GRID_SIZE; r++) begin
      nxt_upd[r] = nxt[r];
    end
    nxt_upd[0][0] = cell_next;
    for (int r = 0; r < GRID_SIZE; r++) begin
      for (int c = 0; c < GRID_SIZE; c++) begin
        grid_h[r][c]  = grid[r][(c + 1) % GRID_SIZE];
        grid_hv[r][c] = grid[(r + 1) % GRID_SIZE][(c + 1) % GRID_SIZE];
        nxt_h[r][c]   = nxt_upd[r][(c + 1) % GRID_SIZE];
        nxt_hv[r][c]  = nxt_upd[(r + 1) % GRID_SIZE][(c + 1) % GRID_SIZE];
      end
    end
  end

  // Grid after a seed item; out-of-range rows and columns are dropped.
  always_comb begin
    for (int r = 0; r < GRID_SIZE; r++) begin
      seed_grid[r] = grid[r];
    end
    if (int'(cmd.row_index) < GRID_SIZE) begin
      seed_grid[cmd.row_index[IDX_W-1:0]] = cmd.row_bits[GRID_SIZE-1:0];
    end
  end

  // Pack the grid that goes out with this item.
  always_comb begin
    for (int r = 0; r < GRID_SIZE; r++) begin
      pack_src[r] = (state == S_STEP) ? nxt_hv[r] : seed_grid[r];
    end
    packed_bits = '0;
    for (int r = 0; r < GRID_SIZE; r++) begin
      for (int c = 0; c < GRID_SIZE; c++) begin
        packed_bits[ROW_W * r + c] = pack_src[r][c];
      end
    end
  end

  // Sequencer, grids and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      col       <= '0;
      row       <= '0;
      for (int r = 0; r < GRID_SIZE; r++) begin
        grid[r] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          // An accepted item always finds the result register free or being emptied.
          if (accept) begin
            if (cmd.mode == MODE_STEP) begin
              state     <= S_STEP;
              col       <= '0;
              row       <= '0;
              out_valid <= 1'b0;
            end else begin
              for (int r = 0; r < GRID_SIZE; r++) begin
                grid[r] <= seed_grid[r];
              end
              out_valid <= 1'b1;
              out_bits  <= packed_bits;
            end
          end else if (result.valid && result.ready) begin
            out_valid <= 1'b0;
          end
        end
        S_STEP: begin
          if (col == LAST) begin
            col <= '0;
            for (int r = 0; r < GRID_SIZE; r++) begin
              nxt[r] <= nxt_hv[r];
            end
            if (row == LAST) begin
              // Pass complete: both grids are back in place.
              state <= S_IDLE;
              for (int r = 0; r < GRID_SIZE; r++) begin
                grid[r] <= nxt_hv[r];
              end
              out_valid <= 1'b1;
              out_bits  <= packed_bits;
            end else begin
              row <= row + 1'b1;
              for (int r = 0; r < GRID_SIZE; r++) begin
                grid[r] <= grid_hv[r];
              end
            end
          end else begin
            col <= col + 1'b1;
            for (int r = 0; r < GRID_SIZE; r++) begin
              grid[r] <= grid_h[r];
              nxt[r]  <= nxt_h[r];
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/tlg_checker.sv
// Port-level checks of the grid stepper and the bind that attaches them.
// Depends on tlg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tlg_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cmd_valid,
  input logic                          cmd_ready,
  input tlg_pkg::mode_t                cmd_mode,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [tlg_pkg::GRID_W-1:0]    res_bits
);
  import tlg_pkg::*;

  // A stalled result holds its value.
  `TLG_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_bits))
  // A seed item yields its result on the next cycle.
  `TLG_ASSERT_NXT(a_seed_lat, cmd_valid && cmd_ready && cmd_mode == MODE_SEED, res_valid)
  // A step item blocks new items and has no result yet on the next cycle.
  `TLG_ASSERT_NXT(a_step_busy, cmd_valid && cmd_ready && cmd_mode == MODE_STEP,
                  !cmd_ready && !res_valid)
  // Items are taken only when the result register is free or being emptied.
  `TLG_ASSERT_IMP(a_ready_free, cmd_ready, !res_valid || res_ready)

endmodule

bind toroidal_life_grid_stepper_core tlg_checker u_tlg_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .cmd_mode  (cmd.mode),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_bits  (result.grid_bits)
);

FILE: dv/life_grid_checker.sv
`timescale 1ns / 1ps
// Checker for the toroidal life grid stepper: watches the command and result channels.
// Keeps its own copy of the grid, predicts each result grid and compares it.
// Depends on tlg_pkg and the channel interfaces in tlg_if.sv.
module life_grid_checker (
  input  logic clk,
  input  logic rst,
  life_in_if   cmd,
  life_out_if  result,
  output int   fail_count,
  output int   pending_count
);
  import tlg_pkg::*;

  localparam int SIDE        = 8;
  // Mismatch lines beyond this many are counted but not printed.
  localparam int PRINT_LIMIT = 50;

  logic [GRID_W-1:0] grid_model;
  logic [GRID_W-1:0] expected_grids[$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
    grid_model    = '0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_LIMIT) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  // Next generation under B3/S23: every cell counts its eight neighbors with wrapped edges.
  function automatic logic [GRID_W-1:0] life_next_gen(input logic [GRID_W-1:0] cur);
    logic [GRID_W-1:0] nxt;
    int                nbrs;
    int                ny;
    int                nx;
    nxt = '0;
    for (int y = 0; y < SIDE; y++) begin
      for (int x = 0; x < SIDE; x++) begin
        nbrs = 0;
        for (int dy = -1; dy <= 1; dy++) begin
          for (int dx = -1; dx <= 1; dx++) begin
            if (dx != 0 || dy != 0) begin
              ny   = (y + dy + SIDE) % SIDE;
              nx   = (x + dx + SIDE) % SIDE;
              nbrs += int'(cur[ny*ROW_W + nx]);
            end
          end
        end
        if (nbrs == int'(BIRTH_COUNT) || (cur[y*ROW_W + x] && nbrs == int'(STAY_COUNT))) begin
          nxt[y*ROW_W + x] = 1'b1;
        end
      end
    end
    return nxt;
  endfunction

  // Results are taken before new commands, so a result is never compared with a grid pushed in the same cycle.
  always @(posedge clk) begin
    logic [GRID_W-1:0] want;
    if (rst) begin
      grid_model = '0;
      expected_grids.delete();
      pending_count <= 0;
    end else begin
      if (result.valid && result.ready) begin
        if (expected_grids.size() == 0) begin
          report_mismatch($sformatf("result item %h with no command waiting", result.grid_bits));
        end else begin
          want = expected_grids.pop_front();
          if (result.grid_bits !== want) begin
            report_mismatch($sformatf("grid_bits got %h, want %h", result.grid_bits, want));
          end
        end
      end
      if (cmd.valid && cmd.ready) begin
        if (cmd.mode == MODE_STEP) begin
          grid_model = life_next_gen(grid_model);
        end else if (int'(cmd.row_index) < SIDE) begin
          grid_model[cmd.row_index*ROW_W +: ROW_W] = cmd.row_bits;
        end
        expected_grids.push_back(grid_model);
      end
      pending_count <= expected_grids.size();
    end
  end

endmodule

FILE: dv/tb_toroidal_life_grid_stepper_core.sv
`timescale 1ns / 1ps
// Top of the grid stepper testbench: clock, reset, command stimulus and result backpressure.
// Depends on tlg_pkg, tlg_if.sv, the core and life_grid_checker, which judges every result.
module tb_toroidal_life_grid_stepper_core;
  import tlg_pkg::*;

  localparam int N_ITEMS      = 1550;
  localparam int QUIET_TAIL   = 150;
  localparam int HOLD_AT_ITEM = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 600000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending_count;
  int   sent_count;
  int   cycle_count;
  logic idle_on;
  logic long_hold;

  life_in_if  cmd_if ();
  life_out_if res_if ();

  toroidal_life_grid_stepper_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_if),
    .result (res_if)
  );

  life_grid_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd_if),
    .result        (res_if),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Hard stop in case the block hangs.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one command item and hold it until accepted; returns at the following falling edge.
  task automatic issue_cmd(input mode_t m, input logic [ROW_IDX_W-1:0] r,
                           input logic [ROW_W-1:0] b);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
    end
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.mode      <= m;
    cmd_if.row_index <= r;
    cmd_if.row_bits  <= b;
    do @(posedge clk); while (!cmd_if.ready);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic seed_row(input logic [ROW_IDX_W-1:0] r, input logic [ROW_W-1:0] b);
    issue_cmd(MODE_SEED, r, b);
  endtask

  // The row fields are ignored in a step, so they carry random values.
  task automatic step_gen();
    issue_cmd(MODE_STEP, ROW_IDX_W'($urandom_range(0, 7)), ROW_W'($urandom));
  endtask

  // Row contents with a random density: sparse, even or dense.
  function automatic logic [ROW_W-1:0] pick_row_bits();
    case ($urandom_range(0, 2))
      0: return ROW_W'($urandom & $urandom);
      1: return ROW_W'($urandom);
      default: return ROW_W'($urandom | $urandom);
    endcase
  endfunction

  // One random sequence: mostly a reseeded grid evolved over several generations.
  task automatic run_life_sequence();
    int kind;
    int start;
    int cnt;
    kind    = $urandom_range(0, 9);
    idle_on = (sent_count < N_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
    if (kind <= 4) begin
      start = $urandom_range(0, 7);
      for (int i = 0; i < 8; i++) begin
        seed_row(ROW_IDX_W'((start + i) % 8), pick_row_bits());
      end
      cnt = $urandom_range(1, 16);
      repeat (cnt) step_gen();
    end else if (kind <= 7) begin
      cnt = $urandom_range(1, 4);
      repeat (cnt) seed_row(ROW_IDX_W'($urandom_range(0, 7)), pick_row_bits());
      cnt = $urandom_range(1, 6);
      repeat (cnt) step_gen();
    end else begin
      cnt = $urandom_range(1, 6);
      repeat (cnt) begin
        issue_cmd(mode_t'($urandom_range(0, 1)), ROW_IDX_W'($urandom_range(0, 7)),
                  ROW_W'($urandom));
      end
    end
  endtask

  // Result side: short random stalls, plus the one long hold-off.
  initial begin
    int burst;
    burst        = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (burst == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 15);
      end
      if (burst > 0) begin
        res_if.ready <= 1'b0;
        burst--;
      end else begin
        res_if.ready <= !long_hold;
      end
    end
  end

  // Long receiver stall while commands keep coming, so the block backs up its input.
  initial begin
    long_hold = 1'b0;
    wait (sent_count >= HOLD_AT_ITEM);
    @(posedge clk);
    long_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold = 1'b0;
  end

  // Reset, directed items, random sequences, drain and verdict.
  initial begin
    rst              = 1'b1;
    idle_on          = 1'b1;
    sent_count       = 0;
    cmd_if.valid     = 1'b0;
    cmd_if.mode      = MODE_SEED;
    cmd_if.row_index = '0;
    cmd_if.row_bits  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // A step on the cleared grid must leave it empty.
    step_gen();
    // Two full rows that touch only across the wrapped top and bottom edges.
    seed_row(3'd0, 8'hFF);
    seed_row(3'd7, 8'hFF);
    step_gen();
    // A full grid dies of overcrowding, then the empty grid stays empty.
    for (int r = 0; r < 8; r++) begin
      seed_row(ROW_IDX_W'(r), 8'hFF);
    end
    step_gen();
    step_gen();
    // Blinker straddling the left and right edges.
    seed_row(3'd3, 8'h83);
    step_gen();
    step_gen();
    seed_row(3'd3, 8'h00);
    // Glider placed across the bottom edge.
    seed_row(3'd7, 8'h02);
    seed_row(3'd0, 8'h04);
    seed_row(3'd1, 8'h07);
    repeat (3) step_gen();

    while (sent_count < N_ITEMS) begin
      run_life_sequence();
    end
    cmd_if.valid <= 1'b0;
    idle_on = 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
